### hw/rtl/c2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the multichannel convolution layer.
// ----------------------------------------------------------------------------
package c2d_pkg;

   localparam int DATA_W     = 16;
   localparam int FUNC_W     = 2;
   localparam int FILT_W     = 6;
   localparam int CHIDX_W    = 2;
   localparam int KIDX_W     = 3;
   localparam int ROW_W      = 10;
   localparam int OUTCOL_W   = 5;
   localparam int VAL_W      = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int MAX_HEIGHT = 1024;
   localparam int BIAS_SHIFT = 8;

   localparam logic [FUNC_W-1:0] FUNC_WEIGHT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BIAS   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PIXEL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FILTERS  = 3'd5;

   typedef struct packed {
      logic accept;
      logic prep;
      logic tap;
      logic load_out;
      logic next_filter;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic tap_last;
      logic pipe_busy;
      logic filt_last;
      logic out_taken;
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/c2d_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2d_if
// Request, response and register-write channels (valid/ready).
// ----------------------------------------------------------------------------
interface c2d_req_if;
   logic                                valid;
   logic                                ready;
   logic [c2d_pkg::FUNC_W-1:0]          func;
   logic [c2d_pkg::FILT_W-1:0]          filter_index;
   logic [c2d_pkg::CHIDX_W-1:0]         channel_index;
   logic [c2d_pkg::KIDX_W-1:0]          kernel_row;
   logic [c2d_pkg::KIDX_W-1:0]          kernel_col;
   logic signed [c2d_pkg::DATA_W-1:0]   sample_value;
   modport source (output valid, func, filter_index, channel_index, kernel_row,
                   kernel_col, sample_value, input ready);
   modport sink   (input valid, func, filter_index, channel_index, kernel_row,
                   kernel_col, sample_value, output ready);
endinterface

interface c2d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [c2d_pkg::FILT_W-1:0]    out_filter;
   logic [c2d_pkg::ROW_W-1:0]     out_row;
   logic [c2d_pkg::OUTCOL_W-1:0]  out_col;
   logic [c2d_pkg::VAL_W-1:0]     conv_value;
   logic                          last;
   logic                          frame_done;
   modport source (output valid, out_filter, out_row, out_col, conv_value, last,
                   frame_done, input ready);
   modport sink   (input valid, out_filter, out_row, out_col, conv_value, last,
                   frame_done, output ready);
endinterface

interface c2d_csr_if;
   logic                            valid;
   logic                            ready;
   logic [c2d_pkg::CSR_IDX_W-1:0]   index;
   logic [c2d_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/c2d_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/c2d_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2d_ctrl
// Sequencer: request intake, per-filter tap sweep, drain and result hand-off.
// ----------------------------------------------------------------------------
module c2d_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire c2d_pkg::status_type status,
   output c2d_pkg::cmd_type         cmd
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_TAP   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.hit) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_TAP;
         end
         ST_TAP: begin
            cmd.tap = 1'b1;
            if (status.tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_taken) begin
               if (status.filt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_filter = 1'b1;
                  state_in        = ST_PREP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/c2d_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2d_dp
// Datapath: registers, stores, raster counters, tap addressing, MAC, output.
// ----------------------------------------------------------------------------
module c2d_dp #(
   parameter int MAX_WIDTH    = 32,
   parameter int MAX_KERNEL   = 7,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_FILTERS  = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [c2d_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [c2d_pkg::FILT_W-1:0]          req_filter_index,
   input  wire logic [c2d_pkg::CHIDX_W-1:0]         req_channel_index,
   input  wire logic [c2d_pkg::KIDX_W-1:0]          req_kernel_row,
   input  wire logic [c2d_pkg::KIDX_W-1:0]          req_kernel_col,
   input  wire logic signed [c2d_pkg::DATA_W-1:0]   req_sample_value,
   c2d_rsp_if.source                                rsp,
   c2d_csr_if.sink                                  csr,
   input  wire c2d_pkg::cmd_type                    cmd,
   output c2d_pkg::status_type                      status
);
   localparam int DW    = c2d_pkg::DATA_W;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int TW    = SW + 2;
   localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int LD    = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
   localparam int LAW   = (LD > 1) ? $clog2(LD) : 1;
   localparam int WD    = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int WAW   = (WD > 1) ? $clog2(WD) : 1;
   localparam int ACC_W = 2 * DW + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL + 1) + 2;
   localparam int RW    = c2d_pkg::ROW_W;

   // ---- register file ----
   logic [5:0]  cfg_w_ff;
   logic [10:0] cfg_h_ff;
   logic [2:0]  cfg_k_ff, cfg_s_ff, cfg_c_ff;
   logic [6:0]  cfg_f_ff;
   logic        csr_wr, csr_hit;

   assign csr.ready = 1'b1;
   assign csr_wr    = csr.valid;
   assign csr_hit   = csr_wr && (csr.index == c2d_pkg::REG_WIDTH
                                 || csr.index == c2d_pkg::REG_HEIGHT
                                 || csr.index == c2d_pkg::REG_KERNEL
                                 || csr.index == c2d_pkg::REG_STRIDE
                                 || csr.index == c2d_pkg::REG_CHANNELS
                                 || csr.index == c2d_pkg::REG_FILTERS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= 6'd28;
         cfg_h_ff <= 11'd28;
         cfg_k_ff <= 3'd5;
         cfg_s_ff <= 3'd1;
         cfg_c_ff <= 3'd1;
         cfg_f_ff <= 7'd42;
      end else if (csr_wr) begin
         case (csr.index)
            c2d_pkg::REG_WIDTH:    cfg_w_ff <= csr.data[5:0];
            c2d_pkg::REG_HEIGHT:   cfg_h_ff <= csr.data;
            c2d_pkg::REG_KERNEL:   cfg_k_ff <= csr.data[2:0];
            c2d_pkg::REG_STRIDE:   cfg_s_ff <= csr.data[2:0];
            c2d_pkg::REG_CHANNELS: cfg_c_ff <= csr.data[2:0];
            c2d_pkg::REG_FILTERS:  cfg_f_ff <= csr.data[6:0];
            default: ;
         endcase
      end
   end

   // effective (clamped) settings
   logic [5:0]  eff_w;
   logic [10:0] eff_h;
   logic [2:0]  eff_k, eff_s, eff_c;
   logic [6:0]  eff_f;

   assign eff_w = (cfg_w_ff == '0) ? 6'd1 : (32'(cfg_w_ff) > MAX_WIDTH) ? 6'(MAX_WIDTH) : cfg_w_ff;
   assign eff_h = (cfg_h_ff == '0) ? 11'd1
                : (32'(cfg_h_ff) > c2d_pkg::MAX_HEIGHT) ? 11'(c2d_pkg::MAX_HEIGHT) : cfg_h_ff;
   assign eff_k = (cfg_k_ff == '0) ? 3'd1 : (32'(cfg_k_ff) > MAX_KERNEL) ? 3'(MAX_KERNEL) : cfg_k_ff;
   assign eff_s = (cfg_s_ff == '0) ? 3'd1 : cfg_s_ff;
   assign eff_c = (cfg_c_ff == '0) ? 3'd1
                : (32'(cfg_c_ff) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : cfg_c_ff;
   assign eff_f = (cfg_f_ff == '0) ? 7'd1
                : (32'(cfg_f_ff) > MAX_FILTERS) ? 7'(MAX_FILTERS) : cfg_f_ff;

   // ---- raster counters ----
   logic [RW-1:0]  row_ff, oi_ff;
   logic [CW-1:0]  col_ff, oj_ff;
   logic [CHW-1:0] ch_ff;
   logic [SW-1:0]  slot_ff;
   logic [2:0]     rph_ff, cph_ff;

   logic        is_pix, pix_acc, ch_last, col_ok, row_ok, fits, hit, col_end, row_end;
   logic [10:0] col1, row1;
   logic [3:0]  cph1, rph1;
   logic [2:0]  cph_wrap, rph_wrap;
   logic [TW-1:0] top_tmp;
   logic [SW-1:0] top_slot;
   logic        fin_win;

   assign is_pix  = (req_func == c2d_pkg::FUNC_PIXEL);
   assign pix_acc = cmd.accept && is_pix;
   assign ch_last = (32'(ch_ff) + 1) >= 32'(eff_c);
   assign col1    = 11'(col_ff) + 11'd1;
   assign row1    = 11'(row_ff) + 11'd1;
   assign col_ok  = (col1 >= 11'(eff_k)) && (cph_ff == '0);
   assign row_ok  = (row1 >= 11'(eff_k)) && (rph_ff == '0);
   assign fits    = (eff_w >= 6'(eff_k)) && (eff_h >= 11'(eff_k));
   assign hit     = is_pix && ch_last && col_ok && row_ok && fits;
   assign col_end = col1 >= 11'(eff_w);
   assign row_end = row1 >= eff_h;
   assign cph1    = 4'(cph_ff) + 4'd1;
   assign rph1    = 4'(rph_ff) + 4'd1;
   assign cph_wrap = (cph1 >= 4'(eff_s)) ? 3'd0 : cph1[2:0];
   assign rph_wrap = (rph1 >= 4'(eff_s)) ? 3'd0 : rph1[2:0];
   // slot of the window's top row, modulo the line store height
   assign top_tmp  = TW'(slot_ff) + TW'(MAX_KERNEL) + TW'(1) - TW'(eff_k);
   assign top_slot = (top_tmp >= TW'(MAX_KERNEL)) ? SW'(top_tmp - TW'(MAX_KERNEL))
                                                  : SW'(top_tmp);
   // no further aligned window fits below or to the right
   assign fin_win = (12'(row_ff) + 12'(eff_s) >= 12'(eff_h))
                 && (12'(col_ff) + 12'(eff_s) >= 12'(eff_w));

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         row_ff <= '0; col_ff <= '0; ch_ff <= '0; slot_ff <= '0;
         rph_ff <= '0; cph_ff <= '0; oi_ff <= '0; oj_ff <= '0;
      end else if (pix_acc) begin
         if (!ch_last) begin
            ch_ff <= ch_ff + CHW'(1);
         end else begin
            ch_ff <= '0;
            if (!col_end) begin
               col_ff <= col_ff + CW'(1);
               if (col1 >= 11'(eff_k)) begin
                  cph_ff <= cph_wrap;
                  if (col_ok) begin
                     oj_ff <= oj_ff + CW'(1);
                  end
               end
            end else begin
               col_ff <= '0;
               cph_ff <= '0;
               oj_ff  <= '0;
               if (!row_end) begin
                  row_ff  <= row_ff + RW'(1);
                  slot_ff <= (32'(slot_ff) + 1 >= MAX_KERNEL) ? '0 : slot_ff + SW'(1);
                  if (row1 >= 11'(eff_k)) begin
                     rph_ff <= rph_wrap;
                     if (row_ok) begin
                        oi_ff <= oi_ff + RW'(1);
                     end
                  end
               end else begin
                  row_ff <= '0; slot_ff <= '0; rph_ff <= '0; oi_ff <= '0;
               end
            end
         end
      end
   end

   // ---- window and tap sequencing ----
   logic [SW-1:0]  wtop_ff, ls_ff;
   logic [CW-1:0]  wcol_ff, woj_ff;
   logic [RW-1:0]  woi_ff;
   logic           wfin_ff, first_ff;
   logic [FW-1:0]  f_ff;
   logic [CHW-1:0] c_ff;
   logic [2:0]     r_ff, k_ff;
   logic           k_end, r_end, c_end;

   assign k_end = (4'(k_ff) + 4'd1) >= 4'(eff_k);
   assign r_end = (4'(r_ff) + 4'd1) >= 4'(eff_k);
   assign c_end = (32'(c_ff) + 1) >= 32'(eff_c);

   always_ff @(posedge clock) begin
      if (cmd.accept && hit) begin
         wtop_ff <= top_slot;
         wcol_ff <= CW'(col1 - 11'(eff_k));
         woi_ff  <= oi_ff;
         woj_ff  <= oj_ff;
         wfin_ff <= fin_win;
         f_ff    <= '0;
      end else if (cmd.next_filter) begin
         f_ff <= f_ff + FW'(1);
      end
      if (cmd.prep) begin
         c_ff <= '0; r_ff <= '0; k_ff <= '0;
         ls_ff <= wtop_ff;
      end else if (cmd.tap) begin
         if (!k_end) begin
            k_ff <= k_ff + 3'd1;
         end else begin
            k_ff <= '0;
            if (!r_end) begin
               r_ff  <= r_ff + 3'd1;
               ls_ff <= (32'(ls_ff) + 1 >= MAX_KERNEL) ? '0 : ls_ff + SW'(1);
            end else begin
               r_ff  <= '0;
               ls_ff <= wtop_ff;
               c_ff  <= c_ff + CHW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
      end else begin
         first_ff <= cmd.prep;
      end
   end

   // ---- stores ----
   logic           w_we, b_we, l_we;
   logic [LAW-1:0] l_wa, l_ra;
   logic [WAW-1:0] w_wa, w_ra;
   logic [DW-1:0]  l_q, w_q, b_q;

   assign l_we = pix_acc;
   assign w_we = cmd.accept && (req_func == c2d_pkg::FUNC_WEIGHT)
              && (32'(req_kernel_row) < MAX_KERNEL) && (32'(req_kernel_col) < MAX_KERNEL)
              && (32'(req_channel_index) < MAX_CHANNELS)
              && (32'(req_filter_index) < MAX_FILTERS);
   assign b_we = cmd.accept && (req_func == c2d_pkg::FUNC_BIAS)
              && (32'(req_filter_index) < MAX_FILTERS);

   assign l_wa = LAW'((32'(slot_ff) * MAX_WIDTH + 32'(col_ff)) * MAX_CHANNELS + 32'(ch_ff));
   assign l_ra = LAW'((32'(ls_ff) * MAX_WIDTH + 32'(wcol_ff) + 32'(k_ff)) * MAX_CHANNELS
                      + 32'(c_ff));
   assign w_wa = WAW'(((32'(req_filter_index) * MAX_CHANNELS + 32'(req_channel_index))
                       * MAX_KERNEL + 32'(req_kernel_row)) * MAX_KERNEL + 32'(req_kernel_col));
   assign w_ra = WAW'(((32'(f_ff) * MAX_CHANNELS + 32'(c_ff)) * MAX_KERNEL + 32'(r_ff))
                      * MAX_KERNEL + 32'(k_ff));

   c2d_ram #(.WIDTH(DW), .DEPTH(LD)) u_line (
      .clock(clock), .wr_en(l_we), .wr_addr(l_wa), .wr_data(req_sample_value),
      .rd_addr(l_ra), .rd_data(l_q));

   c2d_ram #(.WIDTH(DW), .DEPTH(WD)) u_weight (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(req_sample_value),
      .rd_addr(w_ra), .rd_data(w_q));

   c2d_ram #(.WIDTH(DW), .DEPTH(MAX_FILTERS)) u_bias (
      .clock(clock), .wr_en(b_we), .wr_addr(FW'(req_filter_index)),
      .wr_data(req_sample_value), .rd_addr(f_ff), .rd_data(b_q));

   // ---- multiply-accumulate: read, multiply, add ----
   logic                    rd_v_ff, mul_v_ff;
   logic signed [2*DW-1:0]  prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff  <= 1'b0;
         mul_v_ff <= 1'b0;
      end else begin
         rd_v_ff  <= cmd.tap;
         mul_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(l_q) * $signed(w_q);
      if (first_ff) begin
         acc_ff <= ACC_W'($signed(b_q)) <<< c2d_pkg::BIAS_SHIFT;
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // ---- result register ----
   logic                          out_v_ff, out_last_ff, out_fd_ff;
   logic [c2d_pkg::FILT_W-1:0]    out_f_ff;
   logic [RW-1:0]                 out_row_ff;
   logic [c2d_pkg::OUTCOL_W-1:0]  out_col_ff;
   logic [c2d_pkg::VAL_W-1:0]     out_val_ff, relu;
   logic                          filt_last;

   assign filt_last = (32'(f_ff) + 1) >= 32'(eff_f);
   // clamp at zero, saturate at the top of unsigned Q15.16
   assign relu = (acc_ff[ACC_W-1] || acc_ff == '0) ? '0
               : (|acc_ff[ACC_W-2:c2d_pkg::VAL_W]) ? '1 : acc_ff[c2d_pkg::VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_v_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_f_ff    <= c2d_pkg::FILT_W'(f_ff);
         out_row_ff  <= woi_ff;
         out_col_ff  <= c2d_pkg::OUTCOL_W'(woj_ff);
         out_val_ff  <= relu;
         out_last_ff <= filt_last;
         out_fd_ff   <= filt_last && wfin_ff;
      end
   end

   assign rsp.valid      = out_v_ff;
   assign rsp.out_filter = out_f_ff;
   assign rsp.out_row    = out_row_ff;
   assign rsp.out_col    = out_col_ff;
   assign rsp.conv_value = out_val_ff;
   assign rsp.last       = out_last_ff;
   assign rsp.frame_done = out_fd_ff;

   assign status.hit       = hit;
   assign status.tap_last  = k_end && r_end && c_end;
   assign status.pipe_busy = rd_v_ff || mul_v_ff;
   assign status.filt_last = filt_last;
   assign status.out_taken = out_v_ff && rsp.ready;
endmodule
`default_nettype wire

### hw/rtl/conv2d_multichannel_relu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_multichannel_relu
// Strided valid 2-D convolution over several channels with ReLU, Q8.8 in,
// unsigned Q15.16 out.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  req_chan  in   weight / bias / pixel request (func, indices, sample_value)
//  rsp_chan  out  one result per filter: filter, row, col, value, last, frame_done
//  csr_chan  in   register write: index 0..5, data
//
//  Weight, bias and non-completing pixel requests are taken in the idle state.
//  A pixel completing an aligned window holds the request side until every
//  filter is done: per filter one bias fetch, one tap per cycle through the
//  shared multiplier, a drain of the read and multiply registers and the hand-off.
//  A stalled result holds the sequencer. Sync reset; no clearing pass.
// ----------------------------------------------------------------------------
module conv2d_multichannel_relu #(
   parameter int MAX_WIDTH    = 32,
   parameter int MAX_KERNEL   = 7,
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_FILTERS  = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   c2d_req_if.sink   req_chan,
   c2d_rsp_if.source rsp_chan,
   c2d_csr_if.sink   csr_chan
);
   c2d_pkg::cmd_type    cmd;
   c2d_pkg::status_type status;
   logic                req_ready;

   assign req_chan.ready = req_ready;

   // sequencer: intake, tap sweep, drain, hand-off
   c2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, counters, MAC and result register
   c2d_dp #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_FILTERS  (MAX_FILTERS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_chan.func),
      .req_filter_index  (req_chan.filter_index),
      .req_channel_index (req_chan.channel_index),
      .req_kernel_row    (req_chan.kernel_row),
      .req_kernel_col    (req_chan.kernel_col),
      .req_sample_value  (req_chan.sample_value),
      .rsp               (rsp_chan),
      .csr               (csr_chan),
      .cmd               (cmd),
      .status            (status)
   );
endmodule
`default_nettype wire
